[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Constants, types and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 50;
   localparam int CELL_COUNT    = COLUMNS * ROWS;
   localparam int ADDR_W        = $clog2(CELL_COUNT);
   localparam int COPY_END      = COLUMNS * (ROWS - 1);
   localparam int LAST_ROW_BASE = COLUMNS * (ROWS - 1);

   // field widths
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 6;
   localparam int OFFSET_W = 12;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h17;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT  = 2'd0,
      CMD_SET  = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CELL_W-1:0] cell_type;

   function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
      return (c > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : c;
   endfunction

   function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
      return (r > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : r;
   endfunction

   function automatic addr_type cell_addr(input logic [ROW_W-1:0] r,
                                          input logic [COL_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
   endfunction

endpackage

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: screen store in one synchronous RAM, cursor,
// newline, wrap, scroll up with attribute fill, set cursor and cell read.
// ----------------------------------------------------------------------------
// Put and set cursor answer via the execute state, cell read via execute and read.
// A put that scrolls walks the whole screen RAM, one cell a cycle, before it answers.
// A new request is taken only while idle; busy is low when idle.
// Reset clears the screen RAM in one pass with busy high; the
// attribute register may be written during that pass.
// Results show for exactly one cycle on rsp_valid; the receiver cannot stall.
module text_console_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tcw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::COL_W-1:0]     req_col,
   input  logic [tcw_pkg::ROW_W-1:0]     req_row,
   output logic                          rsp_valid,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::OFFSET_W-1:0]  rsp_cursor_offset,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_read_char,
   output logic [tcw_pkg::ATTR_W-1:0]    rsp_read_attr,
   output logic                          rsp_scrolled,
   input  logic                          csr_write_en,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_write_data
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL
   } state_type;

   // screen RAM
   cell_type mem [CELL_COUNT];
   cell_type rd_data_ff;
   logic     mem_we;
   addr_type mem_waddr;
   cell_type mem_wdata;
   addr_type mem_raddr;

   state_type         state_ff, state_in;
   addr_type          cnt_ff, cnt_in;
   logic              wb_vld_ff, wb_vld_in;
   logic              wb_fill_ff, wb_fill_in;
   addr_type          wb_addr_ff, wb_addr_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   addr_type          offset_ff, offset_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;

   logic              accept;
   logic              wrap_row;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wb_addr_ff;
      mem_wdata = rd_data_ff;
      mem_raddr = '0;
      // delayed scroll write-back has first claim on the write port
      if (wb_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wb_addr_ff;
         mem_wdata = wb_fill_ff ? {attr_ff, CHAR_W'(0)} : rd_data_ff;
      end else if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_EXEC && cmd_ff == CMD_PUT && char_ff != NEWLINE_CODE) begin
         mem_we    = 1'b1;
         mem_waddr = offset_ff;
         mem_wdata = {attr_ff, char_ff};
      end
      if (state_ff == ST_EXEC) begin
         mem_raddr = cell_addr(clamp_row(row_ff), clamp_col(col_ff));
      end else if (state_ff == ST_SCROLL && cnt_ff < ADDR_W'(COPY_END)) begin
         mem_raddr = ADDR_W'(cnt_ff + ADDR_W'(COLUMNS));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // next state
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      wb_vld_in       = 1'b0;
      wb_fill_in      = 1'b0;
      wb_addr_in      = cnt_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      offset_in       = offset_ff;
      attr_in         = csr_write_en ? csr_write_data : attr_ff;
      cmd_in          = cmd_ff;
      char_in         = char_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      rsp_valid_in    = 1'b0;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      wrap_row        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = ADDR_W'(cnt_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_cmd);
               char_in  = req_char_code;
               col_in   = req_col;
               row_in   = req_row;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_char_in     = '0;
            rsp_attr_in     = '0;
            rsp_scrolled_in = 1'b0;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
            unique case (cmd_ff)
               CMD_PUT: begin
                  if (char_ff == NEWLINE_CODE) begin
                     cur_col_in = '0;
                     wrap_row   = 1'b1;
                     offset_in  = ADDR_W'(offset_ff - ADDR_W'(cur_col_ff)
                                          + ADDR_W'(COLUMNS));
                  end else begin
                     offset_in = ADDR_W'(offset_ff + 1'b1);
                     if (cur_col_ff == COL_W'(COLUMNS - 1)) begin
                        cur_col_in = '0;
                        wrap_row   = 1'b1;
                     end else begin
                        cur_col_in = COL_W'(cur_col_ff + 1'b1);
                     end
                  end
                  if (wrap_row) begin
                     if (cur_row_ff == ROW_W'(ROWS - 1)) begin
                        // past the last row: scroll, cursor stays on last row
                        offset_in    = ADDR_W'(LAST_ROW_BASE);
                        rsp_valid_in = 1'b0;
                        cnt_in       = '0;
                        state_in     = ST_SCROLL;
                     end else begin
                        cur_row_in = ROW_W'(cur_row_ff + 1'b1);
                     end
                  end
               end
               CMD_SET: begin
                  cur_col_in = clamp_col(col_ff);
                  cur_row_in = clamp_row(row_ff);
                  offset_in  = cell_addr(clamp_row(row_ff), clamp_col(col_ff));
               end
               CMD_READ: begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_READ;
               end
               CMD_NONE: begin
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            rsp_char_in     = rd_data_ff[CHAR_W-1:0];
            rsp_attr_in     = rd_data_ff[CELL_W-1:CHAR_W];
            rsp_scrolled_in = 1'b0;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_SCROLL: begin
            // read row below, write it back in the next cycle through the delay stage
            wb_vld_in  = 1'b1;
            wb_addr_in = cnt_ff;
            wb_fill_in = (cnt_ff >= ADDR_W'(COPY_END));
            if (cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               cnt_in          = '0;
               rsp_char_in     = '0;
               rsp_attr_in     = '0;
               rsp_scrolled_in = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cnt_in = ADDR_W'(cnt_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         wb_vld_ff    <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         offset_ff    <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wb_vld_ff    <= wb_vld_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         offset_ff    <= offset_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wb_fill_ff      <= wb_fill_in;
      wb_addr_ff      <= wb_addr_in;
      cmd_ff          <= cmd_in;
      char_ff         <= char_in;
      col_ff          <= col_in;
      row_ff          <= row_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = cur_col_ff;
   assign rsp_cursor_row    = cur_row_ff;
   assign rsp_cursor_offset = OFFSET_W'(offset_ff);
   assign rsp_read_char     = rsp_char_ff;
   assign rsp_read_attr     = rsp_attr_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;

endmodule
